// ===== design/csv_rfp_pkg.sv =====
// Shared types, codes and constants of the CSV record field parser.
package csv_rfp_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [7:0] RECORD_LIMIT_RESET = 8'd200;
  localparam logic [7:0] LINE_LIMIT_RESET   = 8'd255;
  localparam logic [7:0] RECORD_COUNT_MAX   = 8'd255;
  localparam logic [2:0] MAX_FIELDS         = 3'd4;
  localparam logic [2:0] MIN_FIELDS_OK      = 3'd3;

  // Register indexes of the configuration port.
  localparam logic CFG_RECORD_LIMIT = 1'b0;
  localparam logic CFG_LINE_LIMIT   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // Output queue; the depth must be a power of two.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_FSTART,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_AFTERQ
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       text_start;
    logic       clear_records;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field_index;
    logic [7:0] field_byte;
    logic [2:0] fields_found;
    logic [7:0] record_number;
    logic       last;
  } result_t;

endpackage

// ===== design/csv_record_field_parser.sv =====
// Top level of the CSV record field parser: input register, config, step, result queue.
//
//  Channel   Handshake            Payload
//  input     in_valid/in_ready    char_byte, text_start, clear_records
//  result    out_valid/out_ready  kind, field_index, field_byte, fields_found,
//                                 record_number, last
//  config    cfg_we               cfg_index, cfg_data
//
// One byte per cycle while the queue has room: a byte is taken into the input
// register, then updates the parse state when the queue has room for two results
// and writes its zero to two results into a four-entry queue. A byte that gives two
// results takes two reads of the output, so the queue's single read port sets the
// rate then. With an empty queue the first result reaches the output through the input
// register and the queue. Reset is synchronous; the parser starts halted until a text start.
// A stalled output fills the queue, and the input register then holds its byte.
module csv_record_field_parser
  import csv_rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       text_start,
  input  logic       clear_records,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [1:0] field_index,
  output logic [7:0] field_byte,
  output logic [2:0] fields_found,
  output logic [7:0] record_number,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] record_limit;
  logic [7:0] line_limit;
  in_item_t   item;
  logic       item_valid;
  logic       adv;
  logic       room_two;
  result_t    res0, res1, out_item;
  logic [1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit <= RECORD_LIMIT_RESET;
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECORD_LIMIT: record_limit <= cfg_data;
        CFG_LINE_LIMIT:   line_limit <= cfg_data;
        default:          record_limit <= record_limit;
      endcase
    end
  end

  assign adv      = item_valid && room_two;
  assign in_ready = !item_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.char_byte <= char_byte;
      item.text_start <= text_start;
      item.clear_records <= clear_records;
    end
  end

  csv_rfp_step u_step (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .item         (item),
    .record_limit (record_limit),
    .line_limit   (line_limit),
    .res0         (res0),
    .res1         (res1),
    .res_count    (res_count)
  );

  csv_rfp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (adv ? res_count : 2'd0),
    .wr0        (res0),
    .wr1        (res1),
    .room_two   (room_two),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  assign kind          = out_item.kind;
  assign field_index   = out_item.field_index;
  assign field_byte    = out_item.field_byte;
  assign fields_found  = out_item.fields_found;
  assign record_number = out_item.record_number;
  assign last          = out_item.last;

endmodule

// ===== design/csv_rfp_step.sv =====
// Parser state registers and the per-byte update that yields up to two results.
module csv_rfp_step
  import csv_rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  in_item_t   item,
  input  logic [7:0] record_limit,
  input  logic [7:0] line_limit,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_count
);

  mode_t      mode, mode_next;
  logic [2:0] field_count, field_count_next;
  logic [7:0] line_length, line_length_next;
  logic [7:0] record_count, record_count_next;
  logic       halted, halted_next;

  logic    emit_byte;
  logic    emit_end;
  result_t byte_res;
  result_t end_res;
  logic    ok;
  logic [7:0] c;

  always_comb begin
    c = item.char_byte;
    mode_next = mode;
    field_count_next = field_count;
    line_length_next = line_length;
    record_count_next = record_count;
    halted_next = halted;
    emit_byte = 1'b0;
    emit_end = 1'b0;
    byte_res = '0;
    end_res = '0;
    ok = 1'b0;

    if (item.text_start) begin
      mode_next = MODE_HEADER;
      field_count_next = '0;
      line_length_next = '0;
      halted_next = 1'b0;
      if (item.clear_records) begin
        record_count_next = '0;
      end
    end

    byte_res.kind = KIND_BYTE;
    byte_res.field_byte = c;

    if (!halted_next) begin
      if (mode_next == MODE_HEADER) begin
        if (c == CHAR_NUL) begin
          halted_next = 1'b1;
        end else if (c == CHAR_LF) begin
          mode_next = MODE_FSTART;
        end
      end else if (c == CHAR_NUL || c == CHAR_CR || c == CHAR_LF) begin
        if (line_length_next != 8'd0) begin
          emit_end = 1'b1;
        end
        if (c == CHAR_NUL) begin
          halted_next = 1'b1;
        end
      end else if (line_length_next == 8'd0 && record_count_next >= record_limit) begin
        halted_next = 1'b1;
      end else begin
        line_length_next = line_length_next + 8'd1;
        case (mode_next)
          MODE_PLAIN: begin
            if (c == CHAR_COMMA) begin
              mode_next = MODE_FSTART;
            end else begin
              emit_byte = 1'b1;
            end
          end
          MODE_QUOTED: begin
            if (c == CHAR_QUOTE) begin
              mode_next = MODE_AFTERQ;
            end else begin
              emit_byte = 1'b1;
            end
          end
          default: begin
            // A comma right after a closing quote only separates fields.
            if (mode_next == MODE_AFTERQ && c == CHAR_COMMA) begin
              mode_next = MODE_FSTART;
            end else if (field_count_next >= MAX_FIELDS) begin
              mode_next = MODE_FSTART;
            end else begin
              field_count_next = field_count_next + 3'd1;
              if (c == CHAR_QUOTE) begin
                mode_next = MODE_QUOTED;
              end else if (c == CHAR_COMMA) begin
                mode_next = MODE_FSTART;
              end else begin
                mode_next = MODE_PLAIN;
                emit_byte = 1'b1;
              end
            end
          end
        endcase
        if (line_length_next >= line_limit) begin
          emit_end = 1'b1;
        end
      end
    end

    byte_res.field_index = 2'(field_count_next - 3'd1);
    byte_res.record_number = record_count_next;

    if (emit_end) begin
      ok = (field_count_next >= MIN_FIELDS_OK);
      end_res.kind = ok ? KIND_ACCEPT : KIND_DROP;
      end_res.fields_found = field_count_next;
      end_res.record_number = record_count_next;
      if (ok && record_count_next != RECORD_COUNT_MAX) begin
        record_count_next = record_count_next + 8'd1;
      end
      field_count_next = '0;
      line_length_next = '0;
      mode_next = MODE_FSTART;
    end
    end_res.last = 1'b1;
    byte_res.last = !emit_end;

    res0 = emit_byte ? byte_res : end_res;
    res1 = end_res;
    res_count = {1'b0, emit_byte} + {1'b0, emit_end};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HEADER;
      field_count <= '0;
      line_length <= '0;
      record_count <= '0;
      halted <= 1'b1;
    end else if (adv) begin
      mode <= mode_next;
      field_count <= field_count_next;
      line_length <= line_length_next;
      record_count <= record_count_next;
      halted <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_fields_bounded: assert property (@(posedge clk) disable iff (rst)
    field_count <= MAX_FIELDS)
    else $error("field count above four");
  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    adv && halted && !item.text_start |-> res_count == 2'd0)
    else $error("halted parser produced a result");
  a_reset_header: assert property (@(posedge clk)
    rst |=> mode == MODE_HEADER && halted)
    else $error("parser not in header skip after reset");
`endif

endmodule

// ===== design/csv_rfp_outq.sv =====
// Small result queue that takes up to two results per cycle and gives one while out_ready is high.
module csv_rfp_outq
  import csv_rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    wr0,
  input  result_t    wr1,
  output logic       room_two,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_item
);

  result_t              mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr;
  logic [OQ_PTR_W-1:0]  rd_ptr;
  logic [OQ_CNT_W-1:0]  count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room_two  = (count <= OQ_CNT_W'(OQ_DEPTH - 2)) ||
                     (pop && count == OQ_CNT_W'(OQ_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push_count);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count <= count + OQ_CNT_W'(push_count) - OQ_CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |->
      ({1'b0, count} + (OQ_CNT_W + 1)'(push_count) - (OQ_CNT_W + 1)'(pop))
        <= (OQ_CNT_W + 1)'(OQ_DEPTH))
    else $error("result queue overflow");
  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (rst)
    pop |=> rd_ptr == $past(rd_ptr) + OQ_PTR_W'(1))
    else $error("read pointer did not advance on pop");
`endif

endmodule
